// ----- sv/gzip_header_unwrapper_assert.svh -----
// Assertion macros shared by the gzip header unwrapper modules.
// Depends on a clock named clock and a synchronous reset named reset in scope.
`ifndef GZIP_HEADER_UNWRAPPER_ASSERT_SVH
`define GZIP_HEADER_UNWRAPPER_ASSERT_SVH

// Same-cycle implication.
`define GZU_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("gzu assertion failed");

// Next-cycle implication.
`define GZU_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("gzu assertion failed");

`endif

// ----- sv/gzu_pkg.sv -----
// Types and constants for the gzip header unwrapper.
// No dependencies.
package gzu_pkg;

   typedef enum logic [3:0] {
      PH_ID1      = 4'd0,
      PH_ID2      = 4'd1,
      PH_CM       = 4'd2,
      PH_FLG      = 4'd3,
      PH_FIXED    = 4'd4,
      PH_XLEN_LO  = 4'd5,
      PH_XLEN_HI  = 4'd6,
      PH_EXTRA    = 4'd7,
      PH_NAME     = 4'd8,
      PH_COMMENT  = 4'd9,
      PH_HCRC_LO  = 4'd10,
      PH_HCRC_HI  = 4'd11,
      PH_PAYLOAD  = 4'd12,
      PH_ABSORB   = 4'd13
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_SHORT     = 2'd1,
      ST_BAD_MAGIC = 2'd2,
      ST_CRC_BAD   = 2'd3
   } status_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] payload_offset;
      logic [31:0] payload_length;
   } result_type;

   localparam logic [7:0]  MAGIC_ID1     = 8'h1f;
   localparam logic [7:0]  MAGIC_ID2     = 8'h8b;
   localparam logic [7:0]  METHOD_DEFL   = 8'h08;
   localparam logic [15:0] FIXED_BYTES   = 16'd6;
   localparam int          MIN_MEMBER    = 10;
   localparam int          TRAILER_BYTES = 8;
   localparam logic [31:0] CRC_POLY      = 32'hEDB88320;
   localparam logic [31:0] CRC_PRESET    = 32'hFFFFFFFF;

   localparam int FL_HCRC    = 1;
   localparam int FL_EXTRA   = 2;
   localparam int FL_NAME    = 3;
   localparam int FL_COMMENT = 4;

endpackage

// ----- sv/gzu_crc_byte.sv -----
// Bytewise CRC-32 update, reflected polynomial, one byte per cycle.
// Depends on gzu_pkg.
module gzu_crc_byte import gzu_pkg::*; (
   input  logic [31:0] crc_in,
   input  logic [7:0]  data_byte,
   output logic [31:0] crc_out
);

   always_comb begin
      logic [31:0] c;
      c = crc_in ^ {24'd0, data_byte};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      crc_out = c;
   end

endmodule

// ----- sv/gzu_parser.sv -----
// Header phase machine, counters, header CRC check and result formation.
// Depends on gzu_pkg, gzu_crc_byte and gzip_header_unwrapper_assert.svh.
`include "gzip_header_unwrapper_assert.svh"
module gzu_parser import gzu_pkg::*; #(
   parameter int LENGTH_BITS = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] data_byte,
   input  logic       last_byte,
   output result_type result
);

   phase_type              phase_ff, phase_in;
   logic [4:0]             flags_ff, flags_in;
   logic [LENGTH_BITS-1:0] count_ff, count_in;
   logic [15:0]            skip_ff, skip_in;
   logic [31:0]            crc_ff, crc_in;
   logic [7:0]             stored_ff, stored_in;
   logic [LENGTH_BITS-1:0] hend_ff, hend_in;
   status_type             err_ff, err_in;

   logic [31:0]            crc_upd;
   logic [LENGTH_BITS-1:0] total;
   logic [LENGTH_BITS-1:0] after_hdr;
   logic [LENGTH_BITS:0]   after_trl;
   logic [LENGTH_BITS+31:0] off_wide;
   logic [LENGTH_BITS+31:0] len_wide;

   gzu_crc_byte u_crc (
      .crc_in    (crc_ff),
      .data_byte (data_byte),
      .crc_out   (crc_upd)
   );

   function automatic phase_type skip_absent(phase_type stage, logic [4:0] flags);
      phase_type s;
      s = stage;
      if (s == PH_XLEN_LO && !flags[FL_EXTRA])   s = PH_NAME;
      if (s == PH_NAME    && !flags[FL_NAME])    s = PH_COMMENT;
      if (s == PH_COMMENT && !flags[FL_COMMENT]) s = PH_HCRC_LO;
      if (s == PH_HCRC_LO && !flags[FL_HCRC])    s = PH_PAYLOAD;
      return s;
   endfunction

   assign total = (count_ff == {LENGTH_BITS{1'b1}}) ? count_ff
                                                    : count_ff + {{(LENGTH_BITS-1){1'b0}}, 1'b1};

   // next state
   always_comb begin
      phase_in  = phase_ff;
      flags_in  = flags_ff;
      count_in  = total;
      skip_in   = skip_ff;
      stored_in = stored_ff;
      hend_in   = hend_ff;
      err_in    = err_ff;
      crc_in    = (phase_ff < PH_HCRC_LO) ? crc_upd : crc_ff;
      case (phase_ff)
         PH_ID1: begin
            if (data_byte != MAGIC_ID1) err_in = ST_BAD_MAGIC;
            phase_in = PH_ID2;
         end
         PH_ID2: begin
            if (data_byte != MAGIC_ID2) err_in = ST_BAD_MAGIC;
            phase_in = PH_CM;
         end
         PH_CM: begin
            if (data_byte != METHOD_DEFL) err_in = ST_BAD_MAGIC;
            phase_in = (err_in != ST_OK) ? PH_ABSORB : PH_FLG;
         end
         PH_FLG: begin
            flags_in = data_byte[4:0];
            skip_in  = FIXED_BYTES;
            phase_in = PH_FIXED;
         end
         PH_FIXED: begin
            skip_in = skip_ff - 16'd1;
            if (skip_in == 16'd0) phase_in = skip_absent(PH_XLEN_LO, flags_ff);
         end
         PH_XLEN_LO: begin
            skip_in  = {8'd0, data_byte};
            phase_in = PH_XLEN_HI;
         end
         PH_XLEN_HI: begin
            skip_in = {data_byte, skip_ff[7:0]};
            if (skip_in == 16'd0) phase_in = skip_absent(PH_NAME, flags_ff);
            else                  phase_in = PH_EXTRA;
         end
         PH_EXTRA: begin
            skip_in = skip_ff - 16'd1;
            if (skip_in == 16'd0) phase_in = skip_absent(PH_NAME, flags_ff);
         end
         PH_NAME: begin
            if (data_byte == 8'd0) phase_in = skip_absent(PH_COMMENT, flags_ff);
         end
         PH_COMMENT: begin
            if (data_byte == 8'd0) phase_in = skip_absent(PH_HCRC_LO, flags_ff);
         end
         PH_HCRC_LO: begin
            stored_in = data_byte;
            phase_in  = PH_HCRC_HI;
         end
         PH_HCRC_HI: begin
            if ({data_byte, stored_ff} != ~crc_ff[15:0]) begin
               err_in   = ST_CRC_BAD;
               phase_in = PH_ABSORB;
            end else begin
               phase_in = PH_PAYLOAD;
            end
         end
         default: begin
         end
      endcase
      if (phase_in == PH_PAYLOAD && phase_ff != PH_PAYLOAD) hend_in = total;
   end

   // result
   assign after_hdr = total - hend_in;
   assign after_trl = {1'b0, after_hdr} - (LENGTH_BITS+1)'(TRAILER_BYTES);
   assign off_wide  = {32'd0, hend_in};
   assign len_wide  = {32'd0, after_trl[LENGTH_BITS-1:0]};

   always_comb begin
      result.status         = ST_OK;
      result.payload_offset = 32'd0;
      result.payload_length = 32'd0;
      if (total < LENGTH_BITS'(MIN_MEMBER)) begin
         result.status = ST_SHORT;
      end else if (err_in != ST_OK) begin
         result.status = err_in;
      end else if (phase_in != PH_PAYLOAD) begin
         result.status = ST_SHORT;
      end else if (after_trl[LENGTH_BITS]) begin
         result.status = ST_SHORT;
      end else begin
         result.payload_offset = off_wide[31:0];
         result.payload_length = len_wide[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step && last_byte)) begin
         phase_ff  <= PH_ID1;
         flags_ff  <= 5'd0;
         count_ff  <= '0;
         skip_ff   <= 16'd0;
         crc_ff    <= CRC_PRESET;
         stored_ff <= 8'd0;
         hend_ff   <= '0;
         err_ff    <= ST_OK;
      end else if (step) begin
         phase_ff  <= phase_in;
         flags_ff  <= flags_in;
         count_ff  <= count_in;
         skip_ff   <= skip_in;
         crc_ff    <= crc_in;
         stored_ff <= stored_in;
         hend_ff   <= hend_in;
         err_ff    <= err_in;
      end
   end

   `GZU_ASSERT_NEXT(a_restart_after_last, step && last_byte, phase_ff == PH_ID1 && count_ff == '0)
   `GZU_ASSERT_NOW(a_absorb_has_error, phase_ff == PH_ABSORB, err_ff != ST_OK)
   `GZU_ASSERT_NOW(a_payload_after_header, phase_ff == PH_PAYLOAD, hend_ff <= count_ff)

endmodule

// ----- sv/gzip_header_unwrapper.sv -----
// Unwraps a gzip member header: one byte is taken per cycle into an input register while
// req_ready is high, the parser steps its phase, counters and CRC-32 on the byte held there,
// and on the byte marked last a result with status, payload offset and payload length is
// loaded into the output register. A new byte is accepted every clock unless a last byte is
// held waiting for the output register. Bytes that are not last flow through even while a
// result waits to be taken; a last byte waits in the input register until the output
// register is free.
// Depends on gzu_pkg, gzu_parser and gzip_header_unwrapper_assert.svh.
`include "gzip_header_unwrapper_assert.svh"
module gzip_header_unwrapper import gzu_pkg::*; #(
   parameter int LENGTH_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_payload_offset,
   output logic [31:0] rsp_payload_length
);

   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_data_ff, s1_data_in;
   logic       s1_last_ff, s1_last_in;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff, rsp_in;
   result_type result;
   logic       s1_step;

   assign s1_step   = s1_valid_ff && (!s1_last_ff || !rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_step;

   gzu_parser #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (s1_step),
      .data_byte (s1_data_ff),
      .last_byte (s1_last_ff),
      .result    (result)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_data_in  = s1_data_ff;
      s1_last_in  = s1_last_ff;
      if (req_ready) begin
         s1_valid_in = req_valid;
         s1_data_in  = req_data_byte;
         s1_last_in  = req_last_byte;
      end
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      if (s1_step && s1_last_ff) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_data_ff <= s1_data_in;
      s1_last_ff <= s1_last_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_ff.status;
   assign rsp_payload_offset = rsp_ff.payload_offset;
   assign rsp_payload_length = rsp_ff.payload_length;

   `GZU_ASSERT_NOW(a_stall_only_on_held_last, !req_ready, s1_valid_ff && s1_last_ff && rsp_valid_ff)
   `GZU_ASSERT_NOW(a_error_fields_zero, rsp_valid_ff && rsp_ff.status != ST_OK, rsp_ff.payload_offset == 32'd0 && rsp_ff.payload_length == 32'd0)
   `GZU_ASSERT_NEXT(a_last_loads_result, s1_step && s1_last_ff, rsp_valid_ff)

endmodule

// ----- dv/tb_gzip_header_unwrapper.sv -----
// Self-checking testbench for gzip_header_unwrapper: gzip members go in byte by byte and
// each status, payload offset and payload length is compared with a table entry or model.
// Depends on gzu_pkg and the gzip_header_unwrapper RTL.
`timescale 1ns / 100ps
module tb_gzip_header_unwrapper;
   import gzu_pkg::*;

   localparam int QUIET_TAIL  = 150;
   localparam int HOLD_AFTER  = 12;
   localparam int HOLD_CYCLES = 300;

   typedef enum {FAULT_NONE, FAULT_ID1, FAULT_ID2, FAULT_METHOD, FAULT_HCRC} fault_type;

   typedef struct {
      logic [7:0] flags;
      int         xlen;
      int         name_len;
      int         comment_len;
      int         body_len;
      int         trailer_len;
      fault_type  fault;
      int         cut;
      bit         typed;
      status_type status;
      int         off;
      int         len;
   } member_type;

   typedef struct {
      logic [7:0] data;
      logic       last;
      bit         typed;
      result_type want;
   } request_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = '0;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_payload_offset;
   logic [31:0] rsp_payload_length;

   request_type request_queue[$];
   result_type  pending_results[$];
   request_type cur_req;
   logic        quiet_tail = 1'b0;
   int          send_gap = 0;
   int          stall_left = 0;
   int          hold_left = 0;
   bit          hold_done = 0;
   int          seen_results = 0;
   int          error_count = 0;

   phase_type   hdr_phase;
   logic [4:0]  hdr_flags;
   logic [31:0] seen_bytes;
   logic [15:0] skip_left;
   logic [31:0] crc_acc;
   logic [7:0]  crc_low_saved;
   logic [31:0] hdr_end;
   status_type  err_code;

   member_type directed_cases [23] = '{
      '{8'h00,   0, 0, 0,  0, 8, FAULT_NONE,   0, 1, ST_OK,        10, 0},
      '{8'h00,   0, 0, 0,  6, 8, FAULT_NONE,   0, 1, ST_OK,        10, 6},
      '{8'h00,   0, 0, 0,  0, 8, FAULT_NONE,   1, 1, ST_SHORT,      0, 0},
      '{8'h00,   0, 0, 0,  0, 8, FAULT_ID1,    9, 1, ST_SHORT,      0, 0},
      '{8'h00,   0, 0, 0,  4, 8, FAULT_ID1,    0, 1, ST_BAD_MAGIC,  0, 0},
      '{8'h00,   0, 0, 0,  4, 8, FAULT_ID2,    0, 1, ST_BAD_MAGIC,  0, 0},
      '{8'h00,   0, 0, 0,  4, 8, FAULT_METHOD, 0, 1, ST_BAD_MAGIC,  0, 0},
      '{8'h02,   0, 0, 0,  4, 8, FAULT_NONE,   0, 1, ST_OK,        12, 4},
      '{8'h02,   0, 0, 0,  4, 8, FAULT_HCRC,   0, 1, ST_CRC_BAD,    0, 0},
      '{8'h04,   0, 0, 0,  3, 8, FAULT_NONE,   0, 1, ST_OK,        12, 3},
      '{8'h04,   5, 0, 0,  3, 8, FAULT_NONE,   0, 1, ST_OK,        17, 3},
      '{8'h04, 300, 0, 0,  0, 8, FAULT_NONE,   0, 1, ST_OK,       312, 0},
      '{8'h08,   0, 4, 0,  2, 8, FAULT_NONE,   0, 1, ST_OK,        15, 2},
      '{8'h10,   0, 0, 3,  1, 8, FAULT_NONE,   0, 1, ST_OK,        14, 1},
      '{8'hff,   2, 2, 2,  5, 8, FAULT_NONE,   0, 0, ST_OK,         0, 0},
      '{8'he1,   0, 0, 0,  7, 8, FAULT_NONE,   0, 0, ST_OK,         0, 0},
      '{8'h08,   0, 3, 0,  0, 0, FAULT_NONE,  14, 1, ST_SHORT,      0, 0},
      '{8'h00,   0, 0, 0,  0, 7, FAULT_NONE,   0, 1, ST_SHORT,      0, 0},
      '{8'h00,   0, 0, 0,  0, 0, FAULT_NONE,   0, 1, ST_SHORT,      0, 0},
      '{8'h04,  20, 0, 0,  0, 8, FAULT_NONE,  16, 1, ST_SHORT,      0, 0},
      '{8'h00,   0, 0, 0, 40, 8, FAULT_ID1,    0, 1, ST_BAD_MAGIC,  0, 0},
      '{8'h1e,   3, 2, 2,  2, 8, FAULT_HCRC,   0, 1, ST_CRC_BAD,    0, 0},
      '{8'h1f,   1, 1, 1,  9, 8, FAULT_NONE,   0, 0, ST_OK,         0, 0}
   };

   gzip_header_unwrapper uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_last_byte      (req_last_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_payload_offset (rsp_payload_offset),
      .rsp_payload_length (rsp_payload_length)
   );

   always #10 clock = ~clock;

   function automatic logic [31:0] crc_next(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'h0, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] seen,
                                  input logic [31:0] want);
      error_count++;
      $display("%0t mismatch %s: got %0h, want %0h", $realtime, what, seen, want);
   endtask

   task automatic clear_parser();
      hdr_phase     = PH_ID1;
      hdr_flags     = '0;
      seen_bytes    = '0;
      skip_left     = '0;
      crc_acc       = CRC_PRESET;
      crc_low_saved = '0;
      hdr_end       = '0;
      err_code      = ST_OK;
   endtask

   // skip header parts whose flag is clear and note the header end on reaching the payload
   task automatic enter_part(input phase_type stage, input logic [31:0] total);
      if (stage == PH_XLEN_LO && !hdr_flags[FL_EXTRA])   stage = PH_NAME;
      if (stage == PH_NAME    && !hdr_flags[FL_NAME])    stage = PH_COMMENT;
      if (stage == PH_COMMENT && !hdr_flags[FL_COMMENT]) stage = PH_HCRC_LO;
      if (stage == PH_HCRC_LO && !hdr_flags[FL_HCRC])    stage = PH_PAYLOAD;
      if (stage == PH_PAYLOAD) hdr_end = total;
      hdr_phase = stage;
   endtask

   task automatic parse_header_byte(input logic [7:0] b, input logic last,
                                    output bit produced, output result_type r);
      logic [31:0] total;
      total = (seen_bytes == '1) ? seen_bytes : seen_bytes + 32'd1;
      produced = 0;
      r = '{ST_OK, 32'd0, 32'd0};
      if (hdr_phase < PH_HCRC_LO) crc_acc = crc_next(crc_acc, b);
      case (hdr_phase)
         PH_ID1: begin
            if (b != MAGIC_ID1) err_code = ST_BAD_MAGIC;
            hdr_phase = PH_ID2;
         end
         PH_ID2: begin
            if (b != MAGIC_ID2) err_code = ST_BAD_MAGIC;
            hdr_phase = PH_CM;
         end
         PH_CM: begin
            if (b != METHOD_DEFL) err_code = ST_BAD_MAGIC;
            hdr_phase = (err_code != ST_OK) ? PH_ABSORB : PH_FLG;
         end
         PH_FLG: begin
            hdr_flags = b[4:0];
            skip_left = FIXED_BYTES;
            hdr_phase = PH_FIXED;
         end
         PH_FIXED: begin
            skip_left = skip_left - 16'd1;
            if (skip_left == 0) enter_part(PH_XLEN_LO, total);
         end
         PH_XLEN_LO: begin
            skip_left = {8'h00, b};
            hdr_phase = PH_XLEN_HI;
         end
         PH_XLEN_HI: begin
            skip_left[15:8] = b;
            if (skip_left == 0) enter_part(PH_NAME, total);
            else hdr_phase = PH_EXTRA;
         end
         PH_EXTRA: begin
            skip_left = skip_left - 16'd1;
            if (skip_left == 0) enter_part(PH_NAME, total);
         end
         PH_NAME: begin
            if (b == 8'h00) enter_part(PH_COMMENT, total);
         end
         PH_COMMENT: begin
            if (b == 8'h00) enter_part(PH_HCRC_LO, total);
         end
         PH_HCRC_LO: begin
            crc_low_saved = b;
            hdr_phase = PH_HCRC_HI;
         end
         PH_HCRC_HI: begin
            if ({b, crc_low_saved} != ~crc_acc[15:0]) begin
               err_code = ST_CRC_BAD;
               hdr_phase = PH_ABSORB;
            end else begin
               enter_part(PH_PAYLOAD, total);
            end
         end
         default: ;
      endcase
      seen_bytes = total;
      if (last) begin
         produced = 1;
         if (total < 32'(MIN_MEMBER)) r.status = ST_SHORT;
         else if (err_code != ST_OK) r.status = err_code;
         else if (hdr_phase != PH_PAYLOAD) r.status = ST_SHORT;
         else if (total - hdr_end < 32'(TRAILER_BYTES)) r.status = ST_SHORT;
         else begin
            r.payload_offset = hdr_end;
            r.payload_length = total - hdr_end - 32'(TRAILER_BYTES);
         end
         clear_parser();
      end
   endtask

   task automatic queue_member(input member_type mc);
      logic [7:0]  bytes[$];
      logic [31:0] crc;
      int          keep;
      request_type item;
      bytes.push_back(MAGIC_ID1);
      bytes.push_back(MAGIC_ID2);
      bytes.push_back(METHOD_DEFL);
      bytes.push_back(mc.flags);
      repeat (6) bytes.push_back(8'($urandom));
      if (mc.flags[FL_EXTRA]) begin
         bytes.push_back(8'(mc.xlen));
         bytes.push_back(8'(mc.xlen >> 8));
         repeat (mc.xlen) bytes.push_back(8'($urandom));
      end
      if (mc.flags[FL_NAME]) begin
         repeat (mc.name_len) bytes.push_back(8'($urandom_range(1, 255)));
         bytes.push_back(8'h00);
      end
      if (mc.flags[FL_COMMENT]) begin
         repeat (mc.comment_len) bytes.push_back(8'($urandom_range(1, 255)));
         bytes.push_back(8'h00);
      end
      if (mc.flags[FL_HCRC]) begin
         crc = CRC_PRESET;
         foreach (bytes[i]) crc = crc_next(crc, bytes[i]);
         crc = ~crc;
         if (mc.fault == FAULT_HCRC) crc[15:0] ^= 16'($urandom_range(1, 16'hffff));
         bytes.push_back(crc[7:0]);
         bytes.push_back(crc[15:8]);
      end
      repeat (mc.body_len + mc.trailer_len) bytes.push_back(8'($urandom));
      case (mc.fault)
         FAULT_ID1:    bytes[0] ^= 8'($urandom_range(1, 255));
         FAULT_ID2:    bytes[1] ^= 8'($urandom_range(1, 255));
         FAULT_METHOD: bytes[2] ^= 8'($urandom_range(1, 255));
         default: ;
      endcase
      keep = bytes.size();
      if (mc.cut > 0 && mc.cut < keep) keep = mc.cut;
      else if (mc.cut < 0) keep = $urandom_range(1, keep);
      for (int i = 0; i < keep; i++) begin
         item.data  = bytes[i];
         item.last  = (i == keep - 1);
         item.typed = item.last && mc.typed;
         item.want  = '{mc.status, 32'(mc.off), 32'(mc.len)};
         request_queue.push_back(item);
      end
   endtask

   always @(posedge clock) begin : drive_requests
      request_type next_req;
      if (reset) begin
         req_valid     <= 1'b0;
         req_data_byte <= '0;
         req_last_byte <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (request_queue.size() > 0) begin
            next_req = request_queue.pop_front();
            req_valid     <= 1'b1;
            req_data_byte <= next_req.data;
            req_last_byte <= next_req.last;
            cur_req       <= next_req;
            quiet_tail    <= (request_queue.size() < QUIET_TAIL);
            if (!quiet_tail && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 13);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) seen_results++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!hold_done && seen_results >= HOLD_AFTER) begin
            // hold off long enough for the block to back up into its input
            hold_done = 1;
            hold_left = HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (!quiet_tail && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 13);
         end
      end
   end

   always @(posedge clock) begin : check_results
      bit         produced;
      result_type predicted;
      result_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               report_mismatch("result with none pending", 32'(rsp_status), 32'd0);
            end else begin
               want = pending_results.pop_front();
               if (rsp_status != want.status)
                  report_mismatch("status", 32'(rsp_status), 32'(want.status));
               if (rsp_payload_offset != want.payload_offset)
                  report_mismatch("payload_offset", rsp_payload_offset, want.payload_offset);
               if (rsp_payload_length != want.payload_length)
                  report_mismatch("payload_length", rsp_payload_length, want.payload_length);
            end
         end
         if (req_valid && req_ready) begin
            parse_header_byte(req_data_byte, req_last_byte, produced, predicted);
            if (produced) pending_results.push_back(cur_req.typed ? cur_req.want : predicted);
         end
      end
   end

   initial begin
      member_type  mc;
      request_type item;
      int          n;
      clear_parser();
      foreach (directed_cases[i]) queue_member(directed_cases[i]);
      while (request_queue.size() < 1350) begin
         mc = '{8'($urandom), 0, $urandom_range(0, 6), $urandom_range(0, 6),
                $urandom_range(0, 20), 8, FAULT_NONE, 0, 0, ST_OK, 0, 0};
         mc.xlen = ($urandom_range(0, 19) == 0) ? $urandom_range(256, 280)
                                                : $urandom_range(0, 8);
         n = $urandom_range(0, 99);
         if (n < 70) begin
            queue_member(mc);
         end else if (n < 85) begin
            case ($urandom_range(0, 2))
               0: begin
                  mc.fault = fault_type'($urandom_range(1, 4));
                  if (mc.fault == FAULT_HCRC) mc.flags[FL_HCRC] = 1'b1;
               end
               1: mc.cut = -1;
               default: mc.trailer_len = $urandom_range(0, 7);
            endcase
            queue_member(mc);
         end else begin
            n = $urandom_range(1, 24);
            for (int i = 0; i < n; i++) begin
               item.data  = (i == 0 && $urandom_range(0, 1)) ? MAGIC_ID1 : 8'($urandom);
               item.last  = (i == n - 1);
               item.typed = 0;
               item.want  = '{ST_OK, 32'd0, 32'd0};
               request_queue.push_back(item);
            end
         end
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      while (request_queue.size() != 0 || req_valid) @(negedge clock);
      while (pending_results.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+sv
sv/gzu_pkg.sv
sv/gzu_crc_byte.sv
sv/gzu_parser.sv
sv/gzip_header_unwrapper.sv
dv/tb_gzip_header_unwrapper.sv
